### hw/rtl/tt_pkg.sv
// Shared types and constants of the transposition table.
package tt_pkg;

    localparam int INDEX_BITS = 16;
    localparam int SLOT_COUNT = 1 << INDEX_BITS;

    localparam logic [14:0] MATE_THRESHOLD_RESET = 15'd31872;

    typedef enum logic [1:0] {
        KIND_PROBE,
        KIND_STORE,
        KIND_NEW_SEARCH,
        KIND_CLEAR
    } t_kind;

    localparam logic [1:0] BOUND_EXACT = 2'd0;
    localparam logic [1:0] BOUND_LOWER = 2'd1;
    localparam logic [1:0] BOUND_UPPER = 2'd2;

    typedef struct packed {
        t_kind              kind;
        logic [63:0]        hash_key;
        logic [7:0]         search_depth;
        logic signed [15:0] alpha_bound;
        logic signed [15:0] beta_bound;
        logic [7:0]         ply_distance;
        logic signed [15:0] new_score;
        logic [1:0]         bound_type;
        logic [15:0]        best_move;
    } t_cmd;

    typedef struct packed {
        logic               key_hit;
        logic [15:0]        move_out;
        logic               score_valid;
        logic signed [15:0] score_out;
        logic               exact_hit;
    } t_result;

    typedef struct packed {
        logic [63:0] key;
        logic [15:0] score;
        logic [15:0] move;
        logic [7:0]  depth;
        logic [1:0]  bound;
        logic [7:0]  generation;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

    typedef struct packed {
        logic                  en;
        logic [INDEX_BITS-1:0] addr;
        t_entry                data;
    } t_wr_req;

endpackage

### hw/rtl/tt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module tt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/tt_lookup.sv
// Entry evaluation stage: probe result, replacement decision and result register.
module tt_lookup (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_vld,
    input  tt_pkg::t_cmd           i_cmd,
    input  logic [15:0]            i_store_score,
    input  tt_pkg::t_entry         i_entry,
    input  logic [7:0]             i_gen,
    input  logic [14:0]            i_thr,
    output tt_pkg::t_wr_req        o_wr,
    output logic                   o_strobe,
    output tt_pkg::t_result        o_result
);

    logic                   hit;
    logic                   deep;
    logic                   keep;
    logic                   valid;
    logic                   exact;
    logic signed [16:0]     sc17;
    logic signed [16:0]     thr17;
    logic signed [16:0]     ply17;
    logic signed [16:0]     adj;
    tt_pkg::t_result        n_result;
    logic                   n_strobe;
    logic                   r_strobe;
    tt_pkg::t_result        r_result;

    always_comb begin
        hit   = (i_entry.key == i_cmd.hash_key);
        deep  = hit && (i_entry.depth >= i_cmd.search_depth);
        sc17  = 17'(signed'(i_entry.score));
        thr17 = signed'({2'b00, i_thr});
        ply17 = signed'({9'b0, i_cmd.ply_distance});
        if (sc17 > thr17) begin
            adj = sc17 - ply17;
        end else if (sc17 < -thr17) begin
            adj = sc17 + ply17;
        end else begin
            adj = sc17;
        end

        valid = 1'b0;
        exact = 1'b0;
        unique case (i_entry.bound)
            tt_pkg::BOUND_EXACT: begin
                valid = deep;
                exact = deep;
            end
            tt_pkg::BOUND_LOWER: begin
                valid = deep && (adj >= 17'(i_cmd.beta_bound));
            end
            tt_pkg::BOUND_UPPER: begin
                valid = deep && (adj <= 17'(i_cmd.alpha_bound));
            end
            default: begin
                valid = 1'b0;
            end
        endcase

        n_result.key_hit     = hit;
        n_result.move_out    = hit ? i_entry.move : 16'd0;
        n_result.score_valid = valid;
        n_result.score_out   = valid ? adj[15:0] : 16'sd0;
        n_result.exact_hit   = exact;
        n_strobe = i_vld && (i_cmd.kind == tt_pkg::KIND_PROBE);

        keep = hit && (i_entry.generation == i_gen)
            && (((i_entry.bound == tt_pkg::BOUND_EXACT)
                 && (i_cmd.bound_type != tt_pkg::BOUND_EXACT))
                || (i_entry.depth > i_cmd.search_depth));

        o_wr.en              = i_vld && (i_cmd.kind == tt_pkg::KIND_STORE) && !keep;
        o_wr.addr            = i_cmd.hash_key[tt_pkg::INDEX_BITS-1:0];
        o_wr.data.key        = i_cmd.hash_key;
        o_wr.data.score      = i_store_score;
        o_wr.data.move       = i_cmd.best_move;
        o_wr.data.depth      = i_cmd.search_depth;
        o_wr.data.bound      = i_cmd.bound_type;
        o_wr.data.generation = i_gen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
        end
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

### hw/rtl/transposition_table.sv
// Top level of the direct-mapped transposition table.
//
// A command transaction is taken at a clock edge where start is high and busy
// is low; i_cmd.kind selects probe, store, new search or clear. Every probe
// gives exactly one result, shown on o_result for one cycle with o_strobe,
// after the command and result registers. Store, new search and clear give
// no result. One command can be taken every cycle unless busy: the table entry
// is read in the cycle the command is taken and modified and written back in
// the next, and a write to the entry read at the same time is forwarded. The
// result cannot be held off; the receiver always takes it. After reset, and
// after a clear command, the table is swept to zero one entry per cycle; busy
// stays high for the clear command and until all 2^INDEX_BITS (65536) entries
// are clear. mate_threshold (i_cfg_we, i_cfg_data) resets to 31872; the user
// must write it only while no command is in flight, which is not enforced.
module transposition_table (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  tt_pkg::t_cmd    i_cmd,
    input  logic            i_cfg_we,
    input  logic [14:0]     i_cfg_data,
    output logic            o_strobe,
    output tt_pkg::t_result o_result
);

    logic                          accept;
    logic                          r_vld;
    tt_pkg::t_cmd                  r_cmd;
    logic [15:0]                   r_store_score;
    logic [15:0]                   n_store_score;
    logic                          r_fwd_vld;
    tt_pkg::t_entry                r_fwd;
    logic [7:0]                    r_gen;
    logic [14:0]                   r_thr;
    logic                          r_clearing;
    logic [tt_pkg::INDEX_BITS-1:0] r_clr_addr;
    logic [tt_pkg::ENTRY_BITS-1:0] rdata;
    tt_pkg::t_entry                entry;
    tt_pkg::t_wr_req               lk_wr;
    logic                          ram_we;
    logic [tt_pkg::INDEX_BITS-1:0] ram_waddr;
    tt_pkg::t_entry                ram_wdata;
    logic [tt_pkg::INDEX_BITS-1:0] raddr;
    logic signed [16:0]            s17;
    logic signed [16:0]            thr17;
    logic signed [16:0]            ply17;
    logic signed [16:0]            st17;
    logic                          stage_clear;

    assign stage_clear = r_vld && (r_cmd.kind == tt_pkg::KIND_CLEAR);
    assign busy        = r_clearing || stage_clear;
    assign accept      = start && !busy;
    assign raddr       = i_cmd.hash_key[tt_pkg::INDEX_BITS-1:0];
    assign entry       = r_fwd_vld ? r_fwd : tt_pkg::t_entry'(rdata);

    always_comb begin
        s17   = 17'(i_cmd.new_score);
        thr17 = signed'({2'b00, r_thr});
        ply17 = signed'({9'b0, i_cmd.ply_distance});
        if (s17 > thr17) begin
            st17 = s17 + ply17;
        end else if (s17 < -thr17) begin
            st17 = s17 - ply17;
        end else begin
            st17 = s17;
        end
        n_store_score = st17[15:0];

        if (r_clearing) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = lk_wr.en;
            ram_waddr = lk_wr.addr;
            ram_wdata = lk_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= 1'b0;
            r_fwd_vld  <= 1'b0;
            r_gen      <= 8'd0;
            r_thr      <= tt_pkg::MATE_THRESHOLD_RESET;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_vld     <= accept;
            r_fwd_vld <= accept && lk_wr.en && (lk_wr.addr == raddr);
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            if (stage_clear) begin
                r_gen      <= 8'd0;
                r_clearing <= 1'b1;
                r_clr_addr <= '0;
            end else begin
                if (r_vld && (r_cmd.kind == tt_pkg::KIND_NEW_SEARCH)) begin
                    r_gen <= r_gen + 8'd1;
                end
                if (r_clearing) begin
                    r_clr_addr <= r_clr_addr + tt_pkg::INDEX_BITS'(1);
                    if (r_clr_addr == '1) begin
                        r_clearing <= 1'b0;
                    end
                end
            end
        end
        if (accept) begin
            r_cmd         <= i_cmd;
            r_store_score <= n_store_score;
        end
        r_fwd <= lk_wr.data;
    end

    tt_ram #(
        .WIDTH (tt_pkg::ENTRY_BITS),
        .DEPTH (tt_pkg::SLOT_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    tt_lookup u_lookup (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vld         (r_vld),
        .i_cmd         (r_cmd),
        .i_store_score (r_store_score),
        .i_entry       (entry),
        .i_gen         (r_gen),
        .i_thr         (r_thr),
        .o_wr          (lk_wr),
        .o_strobe      (o_strobe),
        .o_result      (o_result)
    );

endmodule

### hw/rtl/tt_checker.sv
// Port-level checker for the transposition table, bound to the top level.
module tt_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            start,
    input logic            busy,
    input tt_pkg::t_cmd    i_cmd,
    input logic            o_strobe,
    input tt_pkg::t_result o_result
);

    // A probe transaction yields its result after the command and result registers.
    a_probe_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_cmd.kind == tt_pkg::KIND_PROBE) |=> ##1 o_strobe)
        else $error("probe transaction gave no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy && (i_cmd.kind == tt_pkg::KIND_PROBE), 2))
        else $error("result without a probe transaction");

    a_unusable_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.score_valid |->
            (o_result.score_out == 16'sd0) && !o_result.exact_hit)
        else $error("unusable score is not cleared");

    a_exact_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_result.exact_hit || o_result.score_valid) |-> o_result.key_hit)
        else $error("usable score on a key miss");

    // The table is swept clean after reset before any transaction is taken.
    a_reset_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> busy)
        else $error("table not busy clearing after reset");

endmodule

bind transposition_table tt_checker u_tt_checker (.*);

### tb/tt_checker.sv
// Checker for the transposition table: predicts every probe result and compares it.
`timescale 1ns / 1ps

module tb_tt_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic            busy,
    input  tt_pkg::t_cmd    i_cmd,
    input  logic            i_cfg_we,
    input  logic [14:0]     i_cfg_data,
    input  logic            o_strobe,
    input  tt_pkg::t_result o_result,
    output int unsigned     mismatch_count,
    output int unsigned     pending_count,
    output int unsigned     probes_checked,
    output int unsigned     hits_seen
);
    import tt_pkg::*;

    typedef struct packed {
        logic [63:0] key;
        logic [15:0] score;
        logic [15:0] move;
        logic [7:0]  depth;
        logic [1:0]  bound;
        logic [7:0]  gen;
    } t_slot;

    t_slot       slots [int unsigned];
    logic [7:0]  search_gen = '0;
    logic [14:0] mate_thr = MATE_THRESHOLD_RESET;
    t_result     expected_q [$];
    int unsigned errors = 0;
    int unsigned checked = 0;
    int unsigned hits = 0;

    function automatic t_slot read_slot(input logic [63:0] key);
        int unsigned idx;
        idx = int'(key[INDEX_BITS-1:0]);
        if (slots.exists(idx))
            return slots[idx];
        return '0;
    endfunction

    function automatic t_result probe_lookup(input t_cmd c);
        t_slot   e;
        t_result r;
        int      sc;
        int      thr;
        logic    usable;
        logic    exact;
        e = read_slot(c.hash_key);
        r = '0;
        thr = int'(mate_thr);
        usable = 1'b0;
        exact = 1'b0;
        if (e.key == c.hash_key) begin
            r.key_hit = 1'b1;
            r.move_out = e.move;
            if (e.depth >= c.search_depth) begin
                sc = int'($signed(e.score));
                if (sc > thr)
                    sc = sc - int'(c.ply_distance);
                else if (sc < -thr)
                    sc = sc + int'(c.ply_distance);
                case (e.bound)
                    BOUND_EXACT: begin
                        usable = 1'b1;
                        exact = 1'b1;
                    end
                    BOUND_LOWER: usable = (sc >= int'($signed(c.beta_bound)));
                    BOUND_UPPER: usable = (sc <= int'($signed(c.alpha_bound)));
                    default: usable = 1'b0;
                endcase
                if (usable) begin
                    r.score_valid = 1'b1;
                    r.score_out = 16'(sc);
                    r.exact_hit = exact;
                end
            end
        end
        return r;
    endfunction

    function automatic void store_entry(input t_cmd c);
        t_slot e;
        int    st;
        int    thr;
        e = read_slot(c.hash_key);
        thr = int'(mate_thr);
        if (e.key == c.hash_key && e.gen == search_gen) begin
            if (e.bound == BOUND_EXACT && c.bound_type != BOUND_EXACT)
                return;
            if (e.depth > c.search_depth)
                return;
        end
        st = int'($signed(c.new_score));
        if (st > thr)
            st = st + int'(c.ply_distance);
        else if (st < -thr)
            st = st - int'(c.ply_distance);
        e.key = c.hash_key;
        e.score = 16'(st);
        e.move = c.best_move;
        e.depth = c.search_depth;
        e.bound = c.bound_type;
        e.gen = search_gen;
        slots[int'(c.hash_key[INDEX_BITS-1:0])] = e;
    endfunction

    function automatic void apply_command(input t_cmd c);
        case (c.kind)
            KIND_PROBE: expected_q.push_back(probe_lookup(c));
            KIND_STORE: store_entry(c);
            KIND_NEW_SEARCH: search_gen = search_gen + 8'd1;
            default: begin
                slots.delete();
                search_gen = '0;
            end
        endcase
    endfunction

    function automatic void check_result(input t_result got);
        t_result want;
        if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("Unexpected result: hit %0b move %h valid %0b score %0d exact %0b",
                         got.key_hit, got.move_out, got.score_valid, got.score_out,
                         got.exact_hit);
            return;
        end
        want = expected_q.pop_front();
        checked++;
        if (got.key_hit === 1'b1)
            hits++;
        if (got.key_hit !== want.key_hit || got.move_out !== want.move_out
                || got.score_valid !== want.score_valid || got.score_out !== want.score_out
                || got.exact_hit !== want.exact_hit) begin
            errors++;
            if (errors <= 10) begin
                $display("Mismatch, expected: hit %0b move %h valid %0b score %0d exact %0b",
                         want.key_hit, want.move_out, want.score_valid, want.score_out,
                         want.exact_hit);
                $display("            actual: hit %0b move %h valid %0b score %0d exact %0b",
                         got.key_hit, got.move_out, got.score_valid, got.score_out,
                         got.exact_hit);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            slots.delete();
            search_gen = '0;
            mate_thr = MATE_THRESHOLD_RESET;
            expected_q.delete();
        end else begin
            if (o_strobe)
                check_result(o_result);
            if (i_cfg_we)
                mate_thr = i_cfg_data;
            if (start && !busy)
                apply_command(i_cmd);
        end
        mismatch_count <= errors;
        pending_count <= expected_q.size();
        probes_checked <= checked;
        hits_seen <= hits;
    end

endmodule

### tb/tb_transposition_table.sv
// Testbench top for the transposition table: reset, stimulus, idling phases and verdict.
`timescale 1ns / 1ps

module tb_transposition_table;
    import tt_pkg::*;

    localparam int PHASES = 4;
    localparam int PHASE_ITEMS = 130;
    localparam int POOL_SIZE = 12;
    localparam logic [1:0] BOUND_SPARE = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_cmd        i_cmd = '0;
    logic        i_cfg_we = 1'b0;
    logic [14:0] i_cfg_data = '0;
    logic        o_strobe;
    t_result     o_result;

    int unsigned mismatch_count;
    int unsigned pending_count;
    int unsigned probes_checked;
    int unsigned hits_seen;

    int unsigned idle_pct = 0;
    int unsigned commands_sent = 0;
    int          cur_thr = int'(MATE_THRESHOLD_RESET);
    logic [63:0] key_pool [POOL_SIZE];
    int unsigned phase_idle [PHASES] = '{0, 67, 0, 35};
    logic [14:0] phase_thr [PHASES] = '{15'd0, 15'd32767, MATE_THRESHOLD_RESET, 15'd100};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    transposition_table i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    tb_tt_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_result       (o_result),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .probes_checked (probes_checked),
        .hits_seen      (hits_seen)
    );

    function automatic t_cmd make_cmd(input t_kind k, input logic [63:0] key, input int depth,
                                      input int alpha, input int beta, input int ply,
                                      input int score, input logic [1:0] bound,
                                      input logic [15:0] move);
        t_cmd c;
        c.kind = k;
        c.hash_key = key;
        c.search_depth = 8'(depth);
        c.alpha_bound = 16'(alpha);
        c.beta_bound = 16'(beta);
        c.ply_distance = 8'(ply);
        c.new_score = 16'(score);
        c.bound_type = bound;
        c.best_move = move;
        return c;
    endfunction

    function automatic logic [15:0] pick_score();
        int v;
        case ($urandom_range(3))
            0: v = int'($urandom);
            1: begin
                case ($urandom_range(3))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = -32767;
                    default: v = 0;
                endcase
            end
            2: begin
                v = cur_thr + int'($urandom_range(6)) - 3;
                if ($urandom_range(1) == 1)
                    v = -v;
            end
            default: v = int'($urandom_range(600)) - 300;
        endcase
        return 16'(v);
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd        c;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 46)
            c.kind = KIND_PROBE;
        else if (pick < 92)
            c.kind = KIND_STORE;
        else
            c.kind = KIND_NEW_SEARCH;
        if ($urandom_range(9) == 0)
            c.hash_key = {$urandom, $urandom};
        else
            c.hash_key = key_pool[$urandom_range(POOL_SIZE - 1)];
        if ($urandom_range(9) == 0)
            c.search_depth = 8'($urandom);
        else
            c.search_depth = 8'($urandom_range(12));
        c.alpha_bound = pick_score();
        c.beta_bound = pick_score();
        c.ply_distance = 8'($urandom);
        c.new_score = pick_score();
        c.bound_type = 2'($urandom);
        c.best_move = 16'($urandom);
        return c;
    endfunction

    task automatic issue(input t_cmd c);
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        commands_sent++;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        int unsigned guard;
        guard = 0;
        start <= 1'b0;
        do begin
            @(posedge i_clk);
            guard++;
        end while (pending_count != 0 && guard < 1000);
        repeat (4) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic set_threshold(input logic [14:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        cur_thr = int'(v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic generation_wrap();
        logic [63:0] k;
        k = key_pool[4];
        issue(make_cmd(KIND_STORE, k, 10, 0, 0, 0, 50, BOUND_EXACT, 16'h0ABC));
        repeat (256) issue(make_cmd(KIND_NEW_SEARCH, '0, 0, 0, 0, 0, 0, BOUND_EXACT, '0));
        issue(make_cmd(KIND_STORE, k, 5, 0, 0, 0, -70, BOUND_LOWER, 16'h0DEF));
        issue(make_cmd(KIND_PROBE, k, 0, 0, 0, 0, 0, BOUND_EXACT, '0));
    endtask

    initial begin
        logic [63:0] k1;
        logic [63:0] k2;
        logic [63:0] k3;
        logic [63:0] k4;
        logic [15:0] pool_slot [4];
        k1 = 64'h0123_4567_89AB_1000;
        k2 = 64'hFEDC_BA98_7654_1000;
        k3 = 64'hFFFF_FFFF_FFFF_FFFF;
        k4 = 64'h5A5A_0000_0000_2222;
        pool_slot = '{16'h0000, 16'hFFFF, 16'($urandom), 16'($urandom)};
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = {$urandom, $urandom};
            key_pool[i][15:0] = pool_slot[i / 3];
        end
        key_pool[0] = '0;
        key_pool[3] = '1;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        issue(make_cmd(KIND_PROBE, '0, 0, 0, 0, 0, 0, BOUND_EXACT, '0));
        issue(make_cmd(KIND_PROBE, '0, 1, 0, 0, 0, 0, BOUND_EXACT, '0));
        issue(make_cmd(KIND_PROBE, k1, 0, 0, 0, 0, 0, BOUND_EXACT, '0));
        issue(make_cmd(KIND_STORE, k1, 5, 0, 0, 0, 100, BOUND_EXACT, 16'h1234));
        issue(make_cmd(KIND_PROBE, k1, 5, 0, 0, 0, 0, BOUND_EXACT, '0));
        issue(make_cmd(KIND_STORE, k1, 9, 0, 0, 0, 200, BOUND_LOWER, 16'h1111));
        issue(make_cmd(KIND_STORE, k1, 3, 0, 0, 0, 300, BOUND_EXACT, 16'h2222));
        issue(make_cmd(KIND_STORE, k1, 5, 0, 0, 255, 32767, BOUND_EXACT, 16'hFFFF));
        issue(make_cmd(KIND_PROBE, k1, 0, 0, 0, 255, 0, BOUND_EXACT, '0));
        issue(make_cmd(KIND_STORE, k2, 255, 0, 0, 10, -32768, BOUND_LOWER, 16'h8001));
        issue(make_cmd(KIND_PROBE, k2, 255, -32768, 32767, 10, 0, BOUND_EXACT, '0));
        issue(make_cmd(KIND_PROBE, k2, 255, 32767, -32768, 10, 0, BOUND_EXACT, '0));
        issue(make_cmd(KIND_PROBE, k1, 0, 0, 0, 0, 0, BOUND_EXACT, '0));
        issue(make_cmd(KIND_STORE, k3, 0, 0, 0, 0, -5, BOUND_UPPER, 16'h0000));
        issue(make_cmd(KIND_PROBE, k3, 0, -6, 0, 0, 0, BOUND_EXACT, '0));
        issue(make_cmd(KIND_PROBE, k3, 0, -5, 0, 0, 0, BOUND_EXACT, '0));
        issue(make_cmd(KIND_STORE, k4, 4, 0, 0, 0, 7, BOUND_SPARE, 16'h4444));
        issue(make_cmd(KIND_PROBE, k4, 4, 32767, -32768, 0, 0, BOUND_EXACT, '0));
        issue(make_cmd(KIND_STORE, k4, 2, 0, 0, 0, 9, BOUND_EXACT, 16'h5555));
        issue(make_cmd(KIND_NEW_SEARCH, '0, 0, 0, 0, 0, 0, BOUND_EXACT, '0));
        issue(make_cmd(KIND_STORE, k4, 1, 0, 0, 0, -9, BOUND_LOWER, 16'h6666));
        issue(make_cmd(KIND_PROBE, k4, 1, -32768, 32767, 0, 0, BOUND_EXACT, '0));
        issue(make_cmd(KIND_CLEAR, '0, 0, 0, 0, 0, 0, BOUND_EXACT, '0));
        issue(make_cmd(KIND_PROBE, k3, 0, 0, 0, 0, 0, BOUND_EXACT, '0));
        issue(make_cmd(KIND_PROBE, '0, 0, 0, 0, 0, 0, BOUND_EXACT, '0));

        for (int p = 0; p < PHASES; p++) begin
            drain();
            set_threshold(phase_thr[p]);
            idle_pct = phase_idle[p];
            if (p == 1)
                issue(make_cmd(KIND_CLEAR, '0, 0, 0, 0, 0, 0, BOUND_EXACT, '0));
            if (p == 2)
                generation_wrap();
            repeat (PHASE_ITEMS) issue(random_cmd());
        end

        drain();
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d command transactions over %0d mate thresholds and idling phases.",
                 commands_sent, PHASES);
        $display("%0d probe transactions checked, %0d of them key hits, %0d mismatches.",
                 probes_checked, hits_seen, mismatch_count);
        if (pending_count != 0)
            $display("%0d expected probe results never arrived.", pending_count);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Simulation timed out.");
        $display("FAILURE");
        $finish;
    end

endmodule
